@@ rtl/point_in_convex_quad_test_assert.svh @@
// assertion macros for the point in convex quad test block
// no dependencies; included by the modules that carry assertions
`ifndef POINT_IN_CONVEX_QUAD_TEST_ASSERT_SVH
`define POINT_IN_CONVEX_QUAD_TEST_ASSERT_SVH

// checked property, quiet while reset is asserted
`define PCIQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// checked property that also holds through reset
`define PCIQ_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

@@ rtl/pciq_pkg.sv @@
// shared widths and payload types for the point in convex quad test
// no dependencies
package pciq_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_BITS-1:0]  t_diff;
    typedef logic signed [PROD_BITS-1:0]  t_prod;

    // point and edge vectors taken relative to one corner
    typedef struct packed {
        t_diff px;
        t_diff py;
        t_diff e1x;
        t_diff e1y;
        t_diff e3x;
        t_diff e3y;
    } t_rel;

    typedef struct packed {
        t_rel c0;
        t_rel c2;
    } t_diffs;

    // the four cross product halves for one corner
    typedef struct packed {
        t_prod e1x_py;
        t_prod e1y_px;
        t_prod e3x_py;
        t_prod e3y_px;
    } t_cross;

    typedef struct packed {
        t_cross c0;
        t_cross c2;
    } t_prods;

endpackage

@@ rtl/pciq_diff.sv @@
// first pipeline stage: differences relative to corners 0 and 2
// depends on pciq_pkg
module pciq_diff (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  pciq_pkg::t_coord  i_query_x,
    input  pciq_pkg::t_coord  i_query_y,
    input  pciq_pkg::t_coord  i_corner0_x,
    input  pciq_pkg::t_coord  i_corner0_y,
    input  pciq_pkg::t_coord  i_corner1_x,
    input  pciq_pkg::t_coord  i_corner1_y,
    input  pciq_pkg::t_coord  i_corner2_x,
    input  pciq_pkg::t_coord  i_corner2_y,
    input  pciq_pkg::t_coord  i_corner3_x,
    input  pciq_pkg::t_coord  i_corner3_y,
    output logic              o_valid,
    input  logic              i_ready,
    output pciq_pkg::t_diffs  o_diffs
);

    logic             r_valid;
    pciq_pkg::t_diffs r_diffs;
    pciq_pkg::t_diffs n_diffs;

    function automatic pciq_pkg::t_diff sub(input pciq_pkg::t_coord a,
                                            input pciq_pkg::t_coord b);
        return pciq_pkg::t_diff'(a) - pciq_pkg::t_diff'(b);
    endfunction

    always_comb begin
        n_diffs.c0.px  = sub(i_query_x,   i_corner0_x);
        n_diffs.c0.py  = sub(i_query_y,   i_corner0_y);
        n_diffs.c0.e1x = sub(i_corner1_x, i_corner0_x);
        n_diffs.c0.e1y = sub(i_corner1_y, i_corner0_y);
        n_diffs.c0.e3x = sub(i_corner3_x, i_corner0_x);
        n_diffs.c0.e3y = sub(i_corner3_y, i_corner0_y);
        n_diffs.c2.px  = sub(i_query_x,   i_corner2_x);
        n_diffs.c2.py  = sub(i_query_y,   i_corner2_y);
        n_diffs.c2.e1x = sub(i_corner1_x, i_corner2_x);
        n_diffs.c2.e1y = sub(i_corner1_y, i_corner2_y);
        n_diffs.c2.e3x = sub(i_corner3_x, i_corner2_x);
        n_diffs.c2.e3y = sub(i_corner3_y, i_corner2_y);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_diffs <= n_diffs;
        end
    end

    assign o_valid = r_valid;
    assign o_diffs = r_diffs;

endmodule

@@ rtl/pciq_mul.sv @@
// second pipeline stage: the eight cross product halves
// depends on pciq_pkg
module pciq_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  pciq_pkg::t_diffs  i_diffs,
    output logic              o_valid,
    input  logic              i_ready,
    output pciq_pkg::t_prods  o_prods
);

    logic             r_valid;
    pciq_pkg::t_prods r_prods;
    pciq_pkg::t_prods n_prods;

    function automatic pciq_pkg::t_prod mul(input pciq_pkg::t_diff a,
                                            input pciq_pkg::t_diff b);
        return pciq_pkg::t_prod'(a) * pciq_pkg::t_prod'(b);
    endfunction

    function automatic pciq_pkg::t_cross cross_halves(input pciq_pkg::t_rel r);
        pciq_pkg::t_cross c;
        c.e1x_py = mul(r.e1x, r.py);
        c.e1y_px = mul(r.e1y, r.px);
        c.e3x_py = mul(r.e3x, r.py);
        c.e3y_px = mul(r.e3y, r.px);
        return c;
    endfunction

    always_comb begin
        n_prods.c0 = cross_halves(i_diffs.c0);
        n_prods.c2 = cross_halves(i_diffs.c2);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prods <= n_prods;
        end
    end

    assign o_valid = r_valid;
    assign o_prods = r_prods;

endmodule

@@ rtl/pciq_cmp.sv @@
// third pipeline stage: sign tests and the registered result
// depends on pciq_pkg and point_in_convex_quad_test_assert.svh
`include "point_in_convex_quad_test_assert.svh"

module pciq_cmp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  pciq_pkg::t_prods  i_prods,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_inside_res
);

    logic r_valid;
    logic r_inside;
    logic n_inside;
    logic reject0;
    logic reject2;

    // corner 0 wants both edges on the near side, corner 2 the mirror
    assign reject0 = (i_prods.c0.e1x_py < i_prods.c0.e1y_px)
                  || (i_prods.c0.e3x_py > i_prods.c0.e3y_px);
    assign reject2 = (i_prods.c2.e1x_py > i_prods.c2.e1y_px)
                  || (i_prods.c2.e3x_py < i_prods.c2.e3y_px);
    assign n_inside = !(reject0 || reject2);

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_inside <= n_inside;
        end
    end

    assign o_valid      = r_valid;
    assign o_inside_res = r_inside;

    `PCIQ_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !r_valid)
    `PCIQ_ASSERT(a_take_fills, i_clk, i_rst_n, (i_valid && o_ready) |=> r_valid)
    `PCIQ_ASSERT(a_stall_keeps, i_clk, i_rst_n,
        (r_valid && !i_ready) |=> (r_valid && $stable(r_inside)))

endmodule

@@ rtl/point_in_convex_quad_test.sv @@
// top level of the point in convex quadrilateral hit test
// depends on pciq_pkg, pciq_diff, pciq_mul, pciq_cmp
//
// usage:
//   input channel i_valid / o_ready carries one beat per query: the point
//   and the four corners 0..3 in order, corner 2 opposite corner 0, all
//   signed two's complement coordinates
//   output channel o_valid / i_ready carries one beat per query with
//   o_inside_res = 1 when the point lies inside the quad or on an edge
//   pipeline: an accepted beat is loaded into the difference register, then
//   the multiply register, then the compare register that drives o_valid
//   throughput: one beat per cycle while i_ready is high, set by the
//   three-stage pipeline, every stage registered, multipliers in parallel
//   stall: each stage holds its beat while the next stage is full and not
//   draining; o_ready drops only once all three stages are full and
//   i_ready is low, so nothing is lost or repeated
//   reset: synchronous, active low i_rst_n empties the pipeline; the data
//   registers need no reset, so the first beat may follow reset directly
module point_in_convex_quad_test (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  pciq_pkg::t_coord  i_query_x,
    input  pciq_pkg::t_coord  i_query_y,
    input  pciq_pkg::t_coord  i_corner0_x,
    input  pciq_pkg::t_coord  i_corner0_y,
    input  pciq_pkg::t_coord  i_corner1_x,
    input  pciq_pkg::t_coord  i_corner1_y,
    input  pciq_pkg::t_coord  i_corner2_x,
    input  pciq_pkg::t_coord  i_corner2_y,
    input  pciq_pkg::t_coord  i_corner3_x,
    input  pciq_pkg::t_coord  i_corner3_y,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_inside_res
);

    // handshake between the difference and multiply stages
    logic             diff_valid;
    logic             mul_ready;
    pciq_pkg::t_diffs diffs;

    // handshake between the multiply and compare stages
    logic             mul_valid;
    logic             cmp_ready;
    pciq_pkg::t_prods prods;

    // stage 1: point and edge vectors relative to corners 0 and 2,
    // one bit wider than the coordinates so they never wrap
    pciq_diff u_diff (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_query_x   (i_query_x),
        .i_query_y   (i_query_y),
        .i_corner0_x (i_corner0_x),
        .i_corner0_y (i_corner0_y),
        .i_corner1_x (i_corner1_x),
        .i_corner1_y (i_corner1_y),
        .i_corner2_x (i_corner2_x),
        .i_corner2_y (i_corner2_y),
        .i_corner3_x (i_corner3_x),
        .i_corner3_y (i_corner3_y),
        .o_valid     (diff_valid),
        .i_ready     (mul_ready),
        .o_diffs     (diffs)
    );

    // stage 2: eight full-width signed products, one per cross product half
    pciq_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (diff_valid),
        .o_ready (mul_ready),
        .i_diffs (diffs),
        .o_valid (mul_valid),
        .i_ready (cmp_ready),
        .o_prods (prods)
    );

    // stage 3: four sign tests, any wrong sign rejects; zero never rejects
    pciq_cmp u_cmp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (mul_valid),
        .o_ready      (cmp_ready),
        .i_prods      (prods),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_inside_res (o_inside_res)
    );

endmodule
